// ===== hw/rtl/snm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Sobel normal-map block.
// No dependencies; imported by the top level.
package snm_pkg;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUMP_STRENGTH = 2'd2;

    localparam int WIDTH_REG_W    = 12;
    localparam int HEIGHT_REG_W   = 16;
    localparam int STRENGTH_REG_W = 12;
    localparam int ROW_W          = 16;

    // Register reset values.
    localparam logic [WIDTH_REG_W-1:0]    WIDTH_RESET    = 12'd256;
    localparam logic [HEIGHT_REG_W-1:0]   HEIGHT_RESET   = 16'd256;
    localparam logic [STRENGTH_REG_W-1:0] STRENGTH_RESET = 12'd256;

    // Luminance weights in Q0.16; the three sum to 65536.
    localparam int WSUM_W = 24;
    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;
    localparam logic [7:0]  LUMA_DIVISOR = 8'd255;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Input action codes.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LUMA,
        S_UPDATE,
        S_MAG_A,
        S_MAG_B,
        S_SQ_A,
        S_SQ_B,
        S_ROOT_ST,
        S_ROOT,
        S_DIV_ST,
        S_DIV,
        S_EMIT
    } t_state;

    // Normal component under division.
    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } t_comp;

endpackage

// ===== hw/rtl/snm_line_mem.sv =====
`timescale 1ns / 1ps
// Line buffer memory: one write port, one registered read port.
// Holds the upper and middle row luminances of each column side by side.
module snm_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/snm_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Requires the dividend to be below the divisor shifted left by QW.
module snm_divider #(
    parameter int NW = 25,
    parameter int DW = 8,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int IW   = DW + QW;
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [IW-1:0]   r_rem;
    logic [IW-1:0]   r_dsh;
    logic [QW-1:0]   r_q;
    logic            fits;

    assign fits = (r_rem >= r_dsh);

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, shifted divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= IW'(i_num);
            r_dsh <= IW'(i_den) << (QW - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[QW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/snm_isqrt.sv =====
`timescale 1ns / 1ps
// Integer square root, one root bit (two radicand bits) per cycle.
// XW must be even; the result is the floor of the square root.
module snm_isqrt #(
    parameter int XW = 62
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [XW-1:0]   i_x,
    output logic            o_done,
    output logic [XW/2-1:0] o_root
);

    localparam int HW   = XW / 2;
    localparam int CNTW = $clog2(HW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [XW-1:0]   r_x;
    logic [HW+1:0]   r_rem;
    logic [HW-1:0]   r_root;
    logic [HW+1:0]   rem_sh;
    logic [HW+1:0]   trial;
    logic            fits;

    assign rem_sh = {r_rem[HW-1:0], r_x[XW-1:XW-2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Digit recurrence on the remainder and partial root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[HW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/sobel_normal_map_unit.sv =====
`timescale 1ns / 1ps
// Sobel normal-map unit: one pixel word at a time through luma, line buffers,
// 3x3 window, gradient scaling, square root and three component divisions.
// A word with no result frees the input after the read, luma (pixels only) and update
// steps; a result then takes gradient scaling, squares, the bit-serial square root and
// the shared 8-step divider, the final drain going straight to the scaling; a held
// result keeps the emit step waiting until the output register is free.
// A word is taken only in the idle state; the output register frees the result side.
// Reset (synchronous, active low) clears config, state, counters, window, output valid.
module sobel_normal_map_unit import snm_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int LUMA_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_normal_x,
    output logic [7:0]            o_normal_y,
    output logic [7:0]            o_normal_z,
    output logic [7:0]            o_alpha_out,
    output logic                  o_frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH + 2);
    localparam int LB    = LUMA_BITS;
    localparam int SH    = (LB > 16) ? (LB - 16) : 0;
    localparam int GW    = LB + 4;
    localparam int MW    = LB + 2;
    localparam int PRW   = MW + STRENGTH_REG_W;
    localparam int AW    = PRW - SH;
    localparam int UEXP  = LB + 8 - SH;
    localparam int SW    = 2 * AW + 2;
    localparam int RW    = AW + 1;
    localparam int NUMW  = RW + 9;
    localparam int DENW  = RW + 1;
    localparam int XW    = WSUM_W + LB + 1;
    localparam int YW    = XW - 16;
    localparam int LQW   = LB + 1;
    localparam int LK    = YW + 8;
    localparam logic [SW-1:0] U_SQ  = SW'(1) << (2 * UEXP);
    localparam logic [AW-1:0] U_VAL = AW'(1) << UEXP;
    localparam logic [XW-1:0] LUMA_RND = XW'(255) << 15;
    // Reciprocal of the luma divisor, exact for every dividend below 2^YW.
    localparam logic [YW:0] LUMA_RECIP = (YW+1)'(((64'd1 << LK) + 64'(LUMA_DIVISOR) - 64'd1)
                                                 / 64'(LUMA_DIVISOR));

    // Combined gradient of one 3x3 neighborhood: (q column or row) - (p).
    function automatic logic signed [GW-1:0] sobel_diff(
        input logic [LB-1:0] p0, input logic [LB-1:0] p1, input logic [LB-1:0] p2,
        input logic [LB-1:0] q0, input logic [LB-1:0] q1, input logic [LB-1:0] q2
    );
        logic [GW-1:0] sp;
        logic [GW-1:0] sq;
        sp = GW'(p0) + (GW'(p1) << 1) + GW'(p2);
        sq = GW'(q0) + (GW'(q1) << 1) + GW'(q2);
        return signed'(sq - sp);
    endfunction

    // Configuration registers.
    logic [WIDTH_REG_W-1:0]    r_image_width;
    logic [HEIGHT_REG_W-1:0]   r_image_height;
    logic [STRENGTH_REG_W-1:0] r_bump_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RESET;
            r_image_height  <= HEIGHT_RESET;
            r_bump_strength <= STRENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[HEIGHT_REG_W-1:0];
                CFG_BUMP_STRENGTH: r_bump_strength <= i_cfg_data[STRENGTH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size.
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        h_eff = (r_image_height == '0) ? ROW_W'(1) : r_image_height;
    end

    // State.
    t_state           r_state, n_state;
    t_comp            r_comp;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [PW-1:0]    r_pend;
    logic [LB-1:0]    r_win [9];
    logic             r_drn;
    logic             r_last;
    logic [YW-1:0]    r_luma_y;
    logic [LB-1:0]    r_lum;
    logic signed [GW-1:0] r_gx, r_gy;
    logic [AW-1:0]    r_a, r_b;
    logic [SW-1:0]    r_sum;
    logic [RW-1:0]    r_root;
    logic [7:0]       r_qx, r_qy, r_qz;
    logic             r_out_valid;
    logic [7:0]       r_nx, r_ny, r_nz;
    logic             r_out_last;

    // Handshake and dispatch of an accepted word.
    logic in_fire, drn_now, is_ignore, is_final, is_normal;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign drn_now    = (r_pend != '0);
    assign is_ignore  = !drn_now && (i_action == ACT_DRAIN);
    assign is_final   = drn_now && (r_pend == PW'(1));
    assign is_normal  = !is_ignore && !is_final;

    // Luminance dividend: round((weighted sum << LB) / (255 * 65536)).
    logic [WSUM_W-1:0] wsum;
    logic [XW-1:0]     luma_x;
    logic [2*YW:0]     luma_prod;
    logic [LQW-1:0]    luma_q;

    assign wsum = (WSUM_W'(i_red) * WSUM_W'(WEIGHT_R))
                + (WSUM_W'(i_green) * WSUM_W'(WEIGHT_G))
                + (WSUM_W'(i_blue) * WSUM_W'(WEIGHT_B));
    assign luma_x = (XW'(wsum) << LB) + LUMA_RND;

    // Division by 255 as a multiplication by its scaled reciprocal.
    assign luma_prod = (2*YW+1)'(r_luma_y) * (2*YW+1)'(LUMA_RECIP);
    assign luma_q    = luma_prod[LK+LQW-1:LK];

    // Line buffers: upper row in the high half, middle row in the low half.
    logic            mem_rd_en, mem_wr_en;
    logic [2*LB-1:0] mem_rd_data, mem_wr_data;
    logic [LB-1:0]   mem_up, mem_mid;

    assign mem_rd_en = in_fire && is_normal;
    assign mem_wr_en = (r_state == S_UPDATE);
    assign mem_up    = mem_rd_data[2*LB-1:LB];
    assign mem_mid   = mem_rd_data[LB-1:0];

    snm_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(CW), .DATA_W(2*LB)) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_col),
        .i_wr_data (mem_wr_data)
    );

    // Window column sources for the update step.
    logic          first_row;
    logic [LB-1:0] top_v, mid_v;
    logic          col_zero;
    logic [LB-1:0] rt, rm, rb;
    logic          upd_emit;

    assign first_row   = !r_drn && (r_row == '0);
    assign top_v       = first_row ? r_lum : mem_up;
    assign mid_v       = first_row ? r_lum : mem_mid;
    assign mem_wr_data = {mid_v, r_lum};
    assign col_zero    = (r_col == '0);
    assign upd_emit    = col_zero ? (r_row >= ROW_W'(2)) : (r_row != '0);

    // Right gradient column: old column 2 at a row start or final drain, else the new one.
    always_comb begin
        if (r_state == S_UPDATE && !col_zero) begin
            rt = top_v;
            rm = mid_v;
            rb = r_lum;
        end else begin
            rt = r_win[2];
            rm = r_win[5];
            rb = r_win[8];
        end
    end

    logic signed [GW-1:0] gx_w, gy_w;
    assign gx_w = sobel_diff(r_win[1], r_win[4], r_win[7], rt, rm, rb);
    assign gy_w = sobel_diff(r_win[1], r_win[2], rt, r_win[7], r_win[8], rb);

    // Counter updates at the end of a row.
    logic [CW:0]      col_next;
    logic [ROW_W:0]   row_next;
    logic             row_end;

    assign col_next = {1'b0, r_col} + 1'b1;
    assign row_next = {1'b0, r_row} + 1'b1;
    assign row_end  = (col_next >= (CW+1)'(w_eff));

    // Gradient scaling and sum of squares, one multiplier each.
    logic signed [GW-1:0] g_sel;
    logic [GW-1:0]        g_abs;
    logic [PRW-1:0]       prod;
    logic [AW-1:0]        sq_op;
    logic [2*AW-1:0]      sq;

    assign g_sel = (r_state == S_MAG_A) ? r_gx : r_gy;
    assign g_abs = g_sel[GW-1] ? GW'(-g_sel) : GW'(g_sel);
    assign prod  = PRW'(g_abs[MW-1:0]) * PRW'(r_bump_strength);
    assign sq_op = (r_state == S_SQ_A) ? r_a : r_b;
    assign sq    = (2*AW)'(sq_op) * (2*AW)'(sq_op);

    // Square root unit.
    logic          sq_start, sq_done;
    logic [RW-1:0] sq_root;

    assign sq_start = (r_state == S_ROOT_ST);

    snm_isqrt #(.XW(SW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Component numerator 255*(r+t)+r over denominator 2r.
    logic [RW:0]     comp_v;
    logic [NUMW-1:0] comp_num;
    logic [DENW-1:0] comp_den;
    logic            div_start, div_busy, div_done;
    logic [7:0]      div_q;

    always_comb begin
        case (r_comp)
            COMP_X:  comp_v = r_gx[GW-1] ? ((RW+1)'(r_root) + (RW+1)'(r_a))
                                         : ((RW+1)'(r_root) - (RW+1)'(r_a));
            COMP_Y:  comp_v = r_gy[GW-1] ? ((RW+1)'(r_root) + (RW+1)'(r_b))
                                         : ((RW+1)'(r_root) - (RW+1)'(r_b));
            default: comp_v = (RW+1)'(r_root) + (RW+1)'(U_VAL);
        endcase
    end

    assign comp_num  = (NUMW'(comp_v) << 8) - NUMW'(comp_v) + NUMW'(r_root);
    assign comp_den  = {r_root, 1'b0};
    assign div_start = (r_state == S_DIV_ST);

    snm_divider #(.NW(NUMW), .DW(DENW), .QW(8)) u_comp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (comp_num),
        .i_den   (comp_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && is_final) begin
                    n_state = S_MAG_A;
                end else if (in_fire && is_normal) begin
                    n_state = S_READ;
                end
            end
            S_READ:    n_state = r_drn ? S_UPDATE : S_LUMA;
            S_LUMA:    n_state = S_UPDATE;
            S_UPDATE:  n_state = upd_emit ? S_MAG_A : S_IDLE;
            S_MAG_A:   n_state = S_MAG_B;
            S_MAG_B:   n_state = S_SQ_A;
            S_SQ_A:    n_state = S_SQ_B;
            S_SQ_B:    n_state = S_ROOT_ST;
            S_ROOT_ST: n_state = S_ROOT;
            S_ROOT:    n_state = sq_done ? S_DIV_ST : S_ROOT;
            S_DIV_ST:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = (r_comp == COMP_Z) ? S_EMIT : S_DIV_ST;
                end
            end
            S_EMIT:    n_state = out_free ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters, window and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && is_final) begin
                r_col  <= '0;
                r_row  <= '0;
                r_pend <= '0;
            end
            if (r_state == S_UPDATE) begin
                if (col_zero) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k]     <= top_v;
                        r_win[3 + k] <= mid_v;
                        r_win[6 + k] <= r_lum;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[3*k]     <= r_win[3*k + 1];
                        r_win[3*k + 1] <= r_win[3*k + 2];
                    end
                    r_win[2] <= top_v;
                    r_win[5] <= mid_v;
                    r_win[8] <= r_lum;
                end
                if (row_end) begin
                    r_col <= '0;
                    if (!r_drn) begin
                        r_row <= row_next[ROW_W-1:0];
                        if (row_next >= (ROW_W+1)'(h_eff)) begin
                            r_pend <= PW'(w_eff) + 1'b1;
                        end
                    end
                end else begin
                    r_col <= col_next[CW-1:0];
                end
                if (r_drn) begin
                    r_pend <= r_pend - 1'b1;
                end
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_drn    <= drn_now;
            r_last   <= is_final;
            r_luma_y <= luma_x[XW-1:16];
        end
        if (in_fire && is_final) begin
            r_gx <= gx_w;
            r_gy <= gy_w;
        end
        if (r_state == S_READ && r_drn) begin
            r_lum <= mem_mid;
        end
        if (r_state == S_LUMA) begin
            r_lum <= luma_q[LB] ? {LB{1'b1}} : luma_q[LB-1:0];
        end
        if (r_state == S_UPDATE) begin
            r_gx <= gx_w;
            r_gy <= gy_w;
        end
        if (r_state == S_MAG_A) begin
            r_a <= AW'(prod >> SH);
        end
        if (r_state == S_MAG_B) begin
            r_b <= AW'(prod >> SH);
        end
        if (r_state == S_SQ_A) begin
            r_sum <= U_SQ + SW'(sq);
        end
        if (r_state == S_SQ_B) begin
            r_sum <= r_sum + SW'(sq);
        end
        if (r_state == S_ROOT && sq_done) begin
            r_root <= (sq_root == '0) ? RW'(1) : sq_root;
            r_comp <= COMP_X;
        end
        if (r_state == S_DIV && div_done) begin
            case (r_comp)
                COMP_X: begin
                    r_qx   <= div_q;
                    r_comp <= COMP_Y;
                end
                COMP_Y: begin
                    r_qy   <= div_q;
                    r_comp <= COMP_Z;
                end
                default: r_qz <= div_q;
            endcase
        end
        if (r_state == S_EMIT && out_free) begin
            r_nx       <= r_qx;
            r_ny       <= r_qy;
            r_nz       <= r_qz;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_alpha_out  = ALPHA_OPAQUE;
    assign o_frame_last = r_out_last;

    // The line buffer is never read and written in the same cycle.
    a_mem_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("line buffer read and write overlap");

    // Drain count never exceeds one row plus one.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(MAX_WIDTH + 1))
        else $error("drain count out of range");

    // The component divider is only started when free.
    a_comp_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("component divider restarted while busy");

    // A result word only appears from the emit step.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result word without emit step");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_normal_map_unit: table, 8x4 hold-off, random frames.
// Depends on snm_pkg and the unit RTL; results are checked against an in-bench predictor.
module tb_top import snm_pkg::*; ();

    localparam int MAX_W       = 2048;
    localparam int SETTLE_CYC  = 120;
    localparam int ITEM_TARGET = 1350;

    typedef struct packed {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic [7:0] alpha;
        logic       last;
    } normal_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  act;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        bit                    typed;
        normal_t               typed_res;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [7:0]            i_red;
    logic [7:0]            i_green;
    logic [7:0]            i_blue;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_normal_x;
    logic [7:0]            o_normal_y;
    logic [7:0]            o_normal_z;
    logic [7:0]            o_alpha_out;
    logic                  o_frame_last;

    sobel_normal_map_unit dut (.*);

    // Predictor state: registers, line buffers, window and counters.
    logic [WIDTH_REG_W-1:0]    cur_width;
    logic [HEIGHT_REG_W-1:0]   cur_height;
    logic [STRENGTH_REG_W-1:0] cur_strength;
    logic [15:0]               line_upper [MAX_W];
    logic [15:0]               line_middle [MAX_W];
    logic [15:0]               win [9];
    int unsigned               col_cnt;
    int unsigned               row_cnt;
    int unsigned               owed_drains;

    normal_t  normals_due [$];
    dir_row_t dir_rows [$];
    int       errors;
    int       items;
    int       hold_cycles;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [15:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint unsigned s, v;
        s = 64'(WEIGHT_R) * r + 64'(WEIGHT_G) * g + 64'(WEIGHT_B) * b;
        v = ((s << 16) + (64'd255 << 15)) / (64'd255 << 16);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] comp_code(longint t, longint unsigned rt);
        longint unsigned num;
        num = 64'd255 * longint'(longint'(rt) + t) + rt;
        return 8'(num / (2 * rt));
    endfunction

    // Normal from the window, with cl/cm/cr as left, center and right columns.
    function automatic normal_t normal_of(int cl, int cm, int cr, bit last);
        longint gx, gy;
        longint unsigned a, b, u, rt;
        normal_t n;
        gx = (longint'(win[cr]) + 2 * longint'(win[3 + cr]) + longint'(win[6 + cr]))
           - (longint'(win[cl]) + 2 * longint'(win[3 + cl]) + longint'(win[6 + cl]));
        gy = (longint'(win[6 + cl]) + 2 * longint'(win[6 + cm]) + longint'(win[6 + cr]))
           - (longint'(win[cl]) + 2 * longint'(win[cm]) + longint'(win[cr]));
        a = longint'(gx < 0 ? -gx : gx) * cur_strength;
        b = longint'(gy < 0 ? -gy : gy) * cur_strength;
        u = 64'd1 << 24;
        rt = int_sqrt(a * a + b * b + u * u);
        if (rt == 0) rt = 1;
        n.nx = comp_code(gx < 0 ? longint'(a) : -longint'(a), rt);
        n.ny = comp_code(gy < 0 ? longint'(b) : -longint'(b), rt);
        n.nz = comp_code(longint'(u), rt);
        n.alpha = ALPHA_OPAQUE;
        n.last = last;
        return n;
    endfunction

    function automatic int unsigned eff_width();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_W) return MAX_W;
        return 32'(cur_width);
    endfunction

    function automatic int unsigned eff_height();
        return (cur_height == 0) ? 1 : 32'(cur_height);
    endfunction

    // Advance the predictor by one accepted word; has is set when a normal results.
    task automatic predict_normal(input logic act, input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, output bit has, output normal_t res);
        int unsigned w, h, c, rw;
        logic [15:0] lum, top, mid;
        bit draining;
        w = eff_width();
        h = eff_height();
        draining = owed_drains > 0;
        has = 1'b0;
        res = '0;
        c = col_cnt;
        rw = row_cnt;
        if (!draining && act == ACT_DRAIN) return;
        if (draining && owed_drains == 1) begin
            res = normal_of(1, 2, 2, 1'b1);
            has = 1'b1;
            col_cnt = 0;
            row_cnt = 0;
            owed_drains = 0;
            return;
        end
        if (c >= MAX_W) c = MAX_W - 1;
        lum = draining ? line_middle[c] : luma_of(r, g, b);
        if (!draining && rw == 0) begin
            top = lum;
            mid = lum;
        end else begin
            top = line_upper[c];
            mid = line_middle[c];
        end
        if (c == 0) begin
            if (rw >= 2) begin
                res = normal_of(1, 2, 2, 1'b0);
                has = 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
                win[k] = top;
                win[3 + k] = mid;
                win[6 + k] = lum;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                win[k * 3] = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = lum;
            if (rw >= 1) begin
                res = normal_of(0, 1, 2, 1'b0);
                has = 1'b1;
            end
        end
        line_upper[c] = (!draining && rw == 0) ? lum : line_middle[c];
        line_middle[c] = lum;
        if (c + 1 >= w) begin
            col_cnt = 0;
            if (!draining) begin
                row_cnt = rw + 1;
                if (rw + 1 >= h) owed_drains = w + 1;
            end
        end else begin
            col_cnt = c + 1;
        end
        if (draining) owed_drains--;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker: every accepted word is compared with the oldest normal due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normals_due.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                normal_t n;
                n = normals_due.pop_front();
                if (o_normal_x !== n.nx) report_mismatch("normal_x", o_normal_x, n.nx);
                if (o_normal_y !== n.ny) report_mismatch("normal_y", o_normal_y, n.ny);
                if (o_normal_z !== n.nz) report_mismatch("normal_z", o_normal_z, n.nz);
                if (o_alpha_out !== n.alpha) report_mismatch("alpha", o_alpha_out, n.alpha);
                if (o_frame_last !== n.last) report_mismatch("frame_last", o_frame_last, n.last);
            end
        end
    end

    // Receiver: random stalls per word, plus an occasional long hold-off.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one word after a random gap and feed it to the predictor on acceptance.
    task automatic send_word(input logic act, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit typed, input normal_t typed_res);
        int gap;
        bit has;
        normal_t res;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_normal(act, r, g, b, has, res);
        if (has) normals_due.push_back(typed ? typed_res : res);
    endtask

    // Stop offering and let every due normal arrive, then let the block settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:   cur_width = val[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT:  cur_height = val;
            CFG_BUMP_STRENGTH: cur_strength = val[STRENGTH_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row = '{ROW_CFG, idx, val, ACT_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_word(input logic act, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input bit typed, input normal_t n);
        dir_row_t row;
        row = '{ROW_WORD, '0, '0, act, r, g, b, typed, n};
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] rand_chan(int mode);
        if (mode == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // One frame: noisy pixel phase, then the drains owed, some replaced by pixels.
    task automatic run_frame();
        int unsigned npix, ndrain;
        int mode;
        npix = eff_width() * eff_height();
        ndrain = eff_width() + 1;
        mode = $urandom_range(0, 2);
        for (int unsigned p = 0; p < npix; p++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            send_word(ACT_PIXEL, rand_chan(mode), rand_chan(mode), rand_chan(mode), 1'b0, '0);
            items++;
        end
        for (int unsigned d = 0; d < ndrain; d++) begin
            send_word(($urandom_range(0, 4) == 0) ? ACT_PIXEL : ACT_DRAIN,
                      8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            items++;
        end
        if ($urandom_range(0, 5) == 0)
            send_word(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    initial begin
        normal_t flat, flat_last;
        int pick;
        errors = 0;
        items = 0;
        hold_cycles = 0;
        cur_width = WIDTH_RESET;
        cur_height = HEIGHT_RESET;
        cur_strength = STRENGTH_RESET;
        for (int k = 0; k < MAX_W; k++) begin
            line_upper[k] = '0;
            line_middle[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        col_cnt = 0;
        row_cnt = 0;
        owed_drains = 0;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_action <= ACT_PIXEL;
        i_red <= '0;
        i_green <= '0;
        i_blue <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A flat image gives the straight-up normal.
        flat = '{8'd128, 8'd128, 8'd255, ALPHA_OPAQUE, 1'b0};
        flat_last = '{8'd128, 8'd128, 8'd255, ALPHA_OPAQUE, 1'b1};

        // 2x2 white frame: extra drain, drain mid-frame, pixel during drain.
        add_cfg(CFG_IMAGE_WIDTH, 16'd2);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd2);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, flat);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, flat);
        add_word(ACT_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b1, flat);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, flat_last);
        // 3x3 frame at full gain: checkerboard rows, then a green, red and blue row.
        add_cfg(CFG_IMAGE_WIDTH, 16'd3);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd3);
        add_cfg(CFG_BUMP_STRENGTH, 16'd4095);
        add_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_word(ACT_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
        add_word(ACT_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        add_word(ACT_PIXEL, 8'h00, 8'h00, 8'hFF, 1'b0, '0);
        for (int k = 0; k < 4; k++) add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0);
        // Single pixel, height zero taken as one, zero gain.
        add_cfg(CFG_IMAGE_WIDTH, 16'd1);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd0);
        add_cfg(CFG_BUMP_STRENGTH, 16'd0);
        add_word(ACT_PIXEL, 8'h12, 8'hE0, 8'h7F, 1'b0, '0);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0);
        add_word(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, flat_last);

        // Walk the directed table.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_word(dir_rows[i].act, dir_rows[i].red, dir_rows[i].green,
                          dir_rows[i].blue, dir_rows[i].typed, dir_rows[i].typed_res);
            end
        end

        // An 8x4 frame under a long result hold-off, so the input backs up.
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd8);
        write_reg(CFG_IMAGE_HEIGHT, 16'd4);
        write_reg(CFG_BUMP_STRENGTH, 16'd4095);
        hold_cycles = 400;
        run_frame();

        // Random frames with random small sizes and gains.
        while (items < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                pick = $urandom_range(0, 9);
                write_reg(CFG_IMAGE_WIDTH, (pick == 0) ? 16'd0 :
                          (pick == 1) ? 16'($urandom_range(9, 40)) :
                          16'($urandom_range(1, 8)));
                write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 5)));
                pick = $urandom_range(0, 5);
                write_reg(CFG_BUMP_STRENGTH, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd4095 :
                          (pick == 2) ? 16'd256 : 16'($urandom_range(0, 4095)));
            end
            // Now and then stall the result side long enough to back up the input.
            if ($urandom_range(0, 15) == 0) hold_cycles = 400;
            run_frame();
            if ($urandom_range(0, 9) == 0) wait_idle();
        end

        wait_idle();
        if (errors == 0 && normals_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
